FILE: hw/rtl/pstseq_pkg.sv
// Package for the performance-state transition sequencer.
// Holds the action, result and register codes, field widths and the width mask.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pstseq_pkg;

  localparam int DEF_MAX_STATES = 16;

  // input fields
  localparam int ACT_W    = 2;
  localparam int IDX_W    = 4;
  localparam int WORD_W   = 32;
  localparam int STATE_W  = 4;
  localparam int IN_DATA_W = 104;   // 4 + 32 + 32 + 4 + 32, whole bytes

  // output fields
  localparam int PORT_W   = 16;
  localparam int CODE_W   = 3;
  localparam int POLL_W   = 7;
  localparam int OUT_DATA_W = 72;   // 65 bits of fields, padded to bytes
  localparam int OUT_USED_W = 65;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 5;
  localparam int WIDTHREG_W = 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_STATES    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CONTROL_PORT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CONTROL_WIDTH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STATUS_PORT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_STATUS_WIDTH  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_POLLS     = 3'd5;

  localparam logic [WIDTHREG_W-1:0] RST_WIDTH     = 8'd8;
  localparam logic [POLL_W-1:0]     RST_MAX_POLLS = 7'd100;
  localparam logic [WIDTHREG_W-1:0] WIDTH_BYTE    = 8'd8;
  localparam logic [WIDTHREG_W-1:0] WIDTH_WORD    = 8'd16;
  localparam logic [WIDTHREG_W-1:0] WIDTH_DWORD   = 8'd32;
  localparam logic [POLL_W-1:0]     POLL_SAT      = 7'd127;

  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SAMPLE  = 2'd2;

  localparam logic [CODE_W-1:0] RES_OK        = 3'd0;
  localparam logic [CODE_W-1:0] RES_ALREADY   = 3'd1;
  localparam logic [CODE_W-1:0] RES_INVALID   = 3'd2;
  localparam logic [CODE_W-1:0] RES_BAD_WIDTH = 3'd3;
  localparam logic [CODE_W-1:0] RES_TIMEOUT   = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the input item, start the table read
    logic execute;   // table data ready: update state, load result register
  } cmd_t;

  function automatic logic [WORD_W-1:0] width_mask(input logic [WIDTHREG_W-1:0] w);
    logic [WORD_W-1:0] m;
    if (w <= WIDTH_BYTE) m = 32'h0000_00FF;
    else if (w <= WIDTH_WORD) m = 32'h0000_FFFF;
    else m = 32'hFFFF_FFFF;
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pstate_transition_sequencer.sv
// Performance-state transition sequencer, top level.
// Input stream: s_tuser carries the action (load entry, request, status sample).
// Output stream: one result transaction per input transaction.
// Configuration: plain write port, cfg_addr selects the register, no read-back;
// write only while no transaction is in flight.
// Sequence: at the accepting edge the input item is captured and the table, a
// RAM with registered read, is addressed; in the execute state its data is used
// for the state update and the result is loaded into the output register.
// A new transaction is accepted only in the idle state, not while one executes.
// The result sits in an output register; s_tready stays low while it is
// occupied and not being taken, so a stalled receiver holds the input side.
// Reset: synchronous; clears the committed state, pending request and poll
// count and sets the registers to their defaults. Table contents are undefined
// until loaded.
// Depends on pstseq_pkg, pstseq_ctrl, pstseq_dp, pstseq_ram.
`timescale 1ns / 1ps
`default_nettype none

module pstate_transition_sequencer
  import pstseq_pkg::*;
#(
  parameter int MAX_STATES = DEF_MAX_STATES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // entry_index[3:0], control_word[35:4], expected_status[67:36],
  // target_state[71:68], sampled_status[103:72]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // action[1:0]
  input  wire logic [ACT_W-1:0]      s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // write_valid[0], access_port[16:1], write_value[48:17], read_request[49],
  // done_res[50], result_code[53:51], current_state[57:54], polls_used[64:58]
  output logic      [OUT_DATA_W-1:0] m_tdata
);

  cmd_t cmd;

  pstseq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd)
  );

  pstseq_dp #(
    .MAX_STATES(MAX_STATES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/pstseq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pstseq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pstseq_ctrl.sv
// Controller of the sequencer: handshakes and the capture/execute sequence.
// Depends on pstseq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pstseq_ctrl
  import pstseq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  wire logic m_tready,
  output cmd_t      cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  // a new transaction only when the result register is free by the next edge
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign cmd.capture = accept;
  assign cmd.execute = (state == S_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  a_exec_out_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> !m_tvalid)
    else $error("result register occupied while executing");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted item not executed");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> m_tvalid)
    else $error("executed item produced no result");

endmodule

`default_nettype wire

FILE: hw/rtl/pstseq_dp.sv
// Datapath of the sequencer: configuration, state table, transition state,
// result register. Depends on pstseq_pkg and pstseq_ram.
`timescale 1ns / 1ps
`default_nettype none

module pstseq_dp
  import pstseq_pkg::*;
#(
  parameter int MAX_STATES = DEF_MAX_STATES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic [ACT_W-1:0]      s_tuser,
  input  wire cmd_t                  cmd,
  output logic      [OUT_DATA_W-1:0] m_tdata
);

  localparam int AW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int EW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam logic [EW-1:0] MAXS = EW'(MAX_STATES);

  // configuration registers
  logic [CNT_W-1:0]      num_states;
  logic [PORT_W-1:0]     control_port;
  logic [WIDTHREG_W-1:0] control_width;
  logic [PORT_W-1:0]     status_port;
  logic [WIDTHREG_W-1:0] status_width;
  logic [POLL_W-1:0]     max_polls;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states    <= '0;
      control_port  <= '0;
      control_width <= RST_WIDTH;
      status_port   <= '0;
      status_width  <= RST_WIDTH;
      max_polls     <= RST_MAX_POLLS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_NUM_STATES:    num_states    <= cfg_wdata[CNT_W-1:0];
        CFG_CONTROL_PORT:  control_port  <= cfg_wdata;
        CFG_CONTROL_WIDTH: control_width <= cfg_wdata[WIDTHREG_W-1:0];
        CFG_STATUS_PORT:   status_port   <= cfg_wdata;
        CFG_STATUS_WIDTH:  status_width  <= cfg_wdata[WIDTHREG_W-1:0];
        CFG_MAX_POLLS:     max_polls     <= cfg_wdata[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [ACT_W-1:0]   act_q;
  logic [IDX_W-1:0]   idx_q;
  logic [WORD_W-1:0]  cw_q;
  logic [WORD_W-1:0]  es_q;
  logic [STATE_W-1:0] tgt_q;
  logic [WORD_W-1:0]  ss_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= s_tuser;
      idx_q <= s_tdata[3:0];
      cw_q  <= s_tdata[35:4];
      es_q  <= s_tdata[67:36];
      tgt_q <= s_tdata[71:68];
      ss_q  <= s_tdata[103:72];
    end
  end

  // transition state
  logic [STATE_W-1:0] committed;
  logic               pending;
  logic [STATE_W-1:0] pending_target;
  logic [POLL_W-1:0]  poll_count;

  // table: control word low, expected status high
  logic [EW-1:0]         rd_ext;
  logic [EW-1:0]         wr_ext;
  logic                  ram_we;
  logic [2*WORD_W-1:0]   ram_rdata;

  assign rd_ext = (s_tuser == ACT_REQUEST) ? EW'(s_tdata[71:68]) : EW'(pending_target);
  assign wr_ext = EW'(idx_q);
  assign ram_we = cmd.execute && (act_q == ACT_LOAD) && (wr_ext < MAXS);

  pstseq_ram #(
    .WIDTH(2 * WORD_W),
    .DEPTH(MAX_STATES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ext[AW-1:0]),
    .wdata({es_q, cw_q}),
    .raddr(rd_ext[AW-1:0]),
    .rdata(ram_rdata)
  );

  // execute
  logic [EW-1:0]      count_ext;
  logic [EW-1:0]      count_cap;
  logic               ctrl_bad;
  logic               stat_bad;
  logic [WORD_W-1:0]  masked_sample;
  logic [POLL_W-1:0]  limit;
  logic [POLL_W-1:0]  poll_inc;

  logic [STATE_W-1:0] committed_next;
  logic               pending_next;
  logic [STATE_W-1:0] pending_target_next;
  logic [POLL_W-1:0]  poll_count_next;
  logic               wv;
  logic [PORT_W-1:0]  port;
  logic [WORD_W-1:0]  wval;
  logic               rreq;
  logic               done;
  logic [CODE_W-1:0]  code;

  assign count_ext     = EW'(num_states);
  assign count_cap     = (count_ext > MAXS) ? MAXS : count_ext;
  assign ctrl_bad      = control_width > WIDTH_DWORD;
  assign stat_bad      = status_width > WIDTH_DWORD;
  assign masked_sample = ss_q & width_mask(status_width);
  assign limit         = (max_polls == '0) ? POLL_W'(1) : max_polls;
  assign poll_inc      = (poll_count < POLL_SAT) ? poll_count + POLL_W'(1) : poll_count;

  always_comb begin
    committed_next      = committed;
    pending_next        = pending;
    pending_target_next = pending_target;
    poll_count_next     = poll_count;
    wv   = 1'b0;
    port = '0;
    wval = '0;
    rreq = 1'b0;
    done = 1'b0;
    code = RES_OK;
    if (act_q == ACT_REQUEST) begin
      pending_next    = 1'b0;
      poll_count_next = '0;
      priority if (EW'(tgt_q) >= count_cap) begin
        done = 1'b1;
        code = RES_INVALID;
      end else if (tgt_q == committed) begin
        done = 1'b1;
        code = RES_ALREADY;
      end else if (ctrl_bad) begin
        done = 1'b1;
        code = RES_BAD_WIDTH;
      end else begin
        wv   = 1'b1;
        port = control_port;
        wval = ram_rdata[WORD_W-1:0] & width_mask(control_width);
        if (stat_bad) begin
          done = 1'b1;
          code = RES_BAD_WIDTH;
        end else begin
          pending_next        = 1'b1;
          pending_target_next = tgt_q;
          rreq                = 1'b1;
        end
      end
    end else if (act_q == ACT_SAMPLE && pending) begin
      port = status_port;
      if (masked_sample == ram_rdata[2*WORD_W-1:WORD_W]) begin
        committed_next = pending_target;
        pending_next   = 1'b0;
        done           = 1'b1;
        code           = RES_OK;
      end else begin
        poll_count_next = poll_inc;
        if (poll_inc >= limit) begin
          pending_next = 1'b0;
          done         = 1'b1;
          code         = RES_TIMEOUT;
        end else begin
          rreq = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      committed      <= '0;
      pending        <= 1'b0;
      pending_target <= '0;
      poll_count     <= '0;
    end else if (cmd.execute) begin
      committed      <= committed_next;
      pending        <= pending_next;
      pending_target <= pending_target_next;
      poll_count     <= poll_count_next;
    end
  end

  // result register
  logic               o_wv;
  logic [PORT_W-1:0]  o_port;
  logic [WORD_W-1:0]  o_wval;
  logic               o_rreq;
  logic               o_done;
  logic [CODE_W-1:0]  o_code;

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      o_wv   <= wv;
      o_port <= port;
      o_wval <= wval;
      o_rreq <= rreq;
      o_done <= done;
      o_code <= code;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, poll_count, committed, o_code, o_done,
                    o_rreq, o_wval, o_port, o_wv};

  a_wait_not_done: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> !(o_rreq && o_done))
    else $error("result both finished and asking for a sample");

  a_code_needs_done: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> (o_done || o_code == RES_OK))
    else $error("result code set without completion");

  // a load or an idle sample leaves a waiting request pending without asking
  a_wait_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> (!o_rreq || pending))
    else $error("sample requested with no pending request");

endmodule

`default_nettype wire
